/* sv/tlb_pkg.sv */
// Shared types and constants of the two-port learning bridge.
`timescale 1ns / 1ps
`default_nettype none
package tlb_pkg;

	localparam int MAC_W = 48;
	localparam int PERIOD_W = 16;
	localparam int COUNT_OUT_W = 7;
	localparam logic [PERIOD_W-1:0] AGING_RESET = 16'd15;

	// Kind of word taken in by the front end.
	typedef enum logic {
		KIND_FRAME = 1'b0,
		KIND_TICK  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [MAC_W-1:0] src_mac;
		logic [MAC_W-1:0] dst_mac;
		logic             ingress_port;
	} item_t;

	typedef struct packed {
		logic                   forward;
		logic                   egress_port;
		logic                   learned;
		logic                   evicted;
		logic [COUNT_OUT_W-1:0] entry_count;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_COMMIT
	} state_t;

endpackage
`default_nettype wire

/* sv/two_port_learning_bridge.sv */
// Top level of the two-port learning bridge.
// Frame words are looked up in a MAC table of TABLE_DEPTH entries by a scan
// that reads one table entry per cycle; words queue in front while the scan
// runs and results queue behind it. After reset the block first clears the
// table, one entry per cycle, and holds full high meanwhile. The aging
// period is written on the cfg channel, which is always ready and should
// only be used while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module two_port_learning_bridge
	import tlb_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic                   opcode,
	input  wire logic [MAC_W-1:0]       src_mac,
	input  wire logic [MAC_W-1:0]       dst_mac,
	input  wire logic                   ingress_port,
	output logic                        empty,
	input  wire logic                   pop,
	output logic                        forward,
	output logic                        egress_port,
	output logic                        learned,
	output logic                        evicted,
	output logic [COUNT_OUT_W-1:0]      entry_count,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [PERIOD_W-1:0]    cfg_data
);

	logic [PERIOD_W-1:0] aging_period_q;
	logic    item_valid;
	item_t   item;
	logic    item_pop;
	logic    res_space;
	logic    res_push;
	result_t res_in;
	result_t res_out;
	logic    clearing;

	// Aging period register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aging_period_q <= AGING_RESET;
		end else if (cfg_valid && cfg_ready) begin
			aging_period_q <= cfg_data;
		end
	end

	tlb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.opcode       (opcode),
		.src_mac      (src_mac),
		.dst_mac      (dst_mac),
		.ingress_port (ingress_port),
		.hold         (clearing),
		.full         (full),
		.item_valid   (item_valid),
		.item         (item),
		.item_pop     (item_pop)
	);

	tlb_back #(
		.DEPTH (TABLE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.aging_period (aging_period_q),
		.item_valid   (item_valid),
		.item         (item),
		.item_pop     (item_pop),
		.res_space    (res_space),
		.res_push     (res_push),
		.res          (res_in),
		.clearing     (clearing)
	);

	tlb_res_q u_res_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_push  (res_push),
		.res_in    (res_in),
		.res_space (res_space),
		.empty     (empty),
		.pop       (pop),
		.res_out   (res_out)
	);

	// Result word onto the ports.
	assign forward = res_out.forward;
	assign egress_port = res_out.egress_port;
	assign learned = res_out.learned;
	assign evicted = res_out.evicted;
	assign entry_count = res_out.entry_count;

endmodule
`default_nettype wire

/* sv/tlb_front.sv */
// Front end: classifies incoming words and holds them in a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module tlb_front
	import tlb_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic             opcode,
	input  wire logic [MAC_W-1:0] src_mac,
	input  wire logic [MAC_W-1:0] dst_mac,
	input  wire logic             ingress_port,
	input  wire logic             hold,
	output logic                  full,
	output logic                  item_valid,
	output item_t                 item,
	input  wire logic             item_pop
);

	item_t       ent_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        do_push;
	logic        do_pop;
	item_t       cls;

	// Classify the incoming word.
	always_comb begin
		cls.kind = opcode ? KIND_TICK : KIND_FRAME;
		cls.src_mac = src_mac;
		cls.dst_mac = dst_mac;
		cls.ingress_port = ingress_port;
	end

	assign full = (cnt_q == 2'd2) || hold;
	assign do_push = push && !full;
	assign do_pop = item_pop && (cnt_q != 2'd0);
	assign item_valid = (cnt_q != 2'd0);
	assign item = ent_q[rd_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= cls;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule
`default_nettype wire

/* sv/tlb_res_q.sv */
// Result queue of two entries in front of the output ports.
`timescale 1ns / 1ps
`default_nettype none
module tlb_res_q
	import tlb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic res_push,
	input  result_t   res_in,
	output logic      res_space,
	output logic      empty,
	input  wire logic pop,
	output result_t   res_out
);

	result_t    ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_pop;

	assign res_space = (cnt_q != 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign do_pop = pop && !empty;
	assign res_out = ent_q[rd_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (res_push) begin
			ent_q[wr_q] <= res_in;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, res_push} - {1'b0, do_pop};
		end
	end

endmodule
`default_nettype wire

/* sv/tlb_back.sv */
// Back end: table scan, learning, aging and forwarding decision.
`timescale 1ns / 1ps
`default_nettype none
module tlb_back
	import tlb_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [PERIOD_W-1:0] aging_period,
	input  wire logic                item_valid,
	input  item_t                    item,
	output logic                     item_pop,
	input  wire logic                res_space,
	output logic                     res_push,
	output result_t                  res,
	output logic                     clearing
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int TAB_W = MAC_W + 2;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	// Table word: valid, port, MAC.
	logic [TAB_W-1:0] tab_mem [DEPTH];
	logic [IDX_W-1:0] age_mem [DEPTH];

	state_t state_q, state_d;
	item_t  cur_q;

	logic [IDX_W-1:0]    addr_q;
	logic [IDX_W-1:0]    idx_s1;
	logic                vld_s1;
	logic [TAB_W-1:0]    rd_s1;
	logic [IDX_W-1:0]    age_rd_q;
	logic [IDX_W-1:0]    head_q;
	logic [IDX_W-1:0]    tail_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [PERIOD_W-1:0] tick_q;

	logic             src_hit_q, src_port_q;
	logic             dst_hit_q, dst_port_q;
	logic [IDX_W-1:0] dst_idx_q;
	logic             free_hit_q;
	logic [IDX_W-1:0] free_idx_q;

	// Control outputs of the sequencer.
	logic             start;
	logic             issue;
	logic             commit;
	logic             tab_we;
	logic [IDX_W-1:0] tab_wa;
	logic [TAB_W-1:0] tab_wd;
	logic             age_we;
	logic             head_inc;
	logic             tail_inc;
	logic             cnt_inc;
	logic             cnt_dec;
	logic             tick_clr;
	logic             tick_inc;

	logic                rd_valid, rd_port;
	logic [MAC_W-1:0]    rd_mac;
	logic [PERIOD_W-1:0] period;
	logic [PERIOD_W-1:0] tick_nx;
	logic                full_tab;
	logic                dst_eff;
	logic                learn_slot_sel;
	logic [IDX_W-1:0]    learn_slot;
	logic [CNT_W-1:0]    cnt_after;

	function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
		ptr_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	assign rd_valid = rd_s1[TAB_W-1];
	assign rd_port = rd_s1[TAB_W-2];
	assign rd_mac = rd_s1[MAC_W-1:0];
	assign period = (aging_period == '0) ? PERIOD_W'(1) : aging_period;
	assign tick_nx = tick_q + 1'b1;
	assign full_tab = (cnt_q == FULL_CNT);
	assign clearing = (state_q == ST_CLEAR);
	assign item_pop = start;
	assign learn_slot_sel = full_tab;
	assign learn_slot = learn_slot_sel ? age_rd_q : free_idx_q;

	// Sequencer: next state, memory writes and the result.
	always_comb begin
		state_d = state_q;
		start = 1'b0;
		issue = 1'b0;
		commit = 1'b0;
		tab_we = 1'b0;
		tab_wa = addr_q;
		tab_wd = '0;
		age_we = 1'b0;
		head_inc = 1'b0;
		tail_inc = 1'b0;
		cnt_inc = 1'b0;
		cnt_dec = 1'b0;
		tick_clr = 1'b0;
		tick_inc = 1'b0;
		dst_eff = 1'b0;
		cnt_after = cnt_q;
		res.forward = 1'b0;
		res.egress_port = 1'b0;
		res.learned = 1'b0;
		res.evicted = 1'b0;
		res.entry_count = '0;
		unique case (state_q)
			ST_CLEAR: begin
				tab_we = 1'b1;
				if (addr_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid && res_space) begin
					start = 1'b1;
					state_d = (item.kind == KIND_TICK) ? ST_COMMIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (addr_q == LAST_IDX) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				commit = 1'b1;
				state_d = ST_IDLE;
				if (cur_q.kind == KIND_TICK) begin
					if (tick_nx >= period) begin
						tick_clr = 1'b1;
						if (cnt_q != '0) begin
							tab_we = 1'b1;
							tab_wa = age_rd_q;
							head_inc = 1'b1;
							cnt_dec = 1'b1;
							cnt_after = cnt_q - 1'b1;
							res.evicted = 1'b1;
						end
					end else begin
						tick_inc = 1'b1;
					end
				end else begin
					res.egress_port = ~cur_q.ingress_port;
					if (src_hit_q) begin
						res.forward = (src_port_q == cur_q.ingress_port) &&
							(!dst_hit_q || (dst_port_q != cur_q.ingress_port));
					end else begin
						// Learn the source; a full table gives up its oldest slot.
						res.learned = 1'b1;
						tab_we = 1'b1;
						tab_wa = learn_slot;
						tab_wd = {1'b1, cur_q.ingress_port, cur_q.src_mac};
						age_we = 1'b1;
						tail_inc = 1'b1;
						if (full_tab) begin
							head_inc = 1'b1;
							res.evicted = 1'b1;
						end else begin
							cnt_inc = 1'b1;
							cnt_after = cnt_q + 1'b1;
						end
						dst_eff = dst_hit_q && !(full_tab && (dst_idx_q == age_rd_q));
						if (cur_q.dst_mac == cur_q.src_mac) begin
							res.forward = 1'b0;
						end else begin
							res.forward = !dst_eff || (dst_port_q != cur_q.ingress_port);
						end
					end
				end
				res.entry_count = COUNT_OUT_W'(cnt_after);
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res_push = commit;

	// Table and age memories with registered reads.
	always_ff @(posedge clk) begin
		if (tab_we) begin
			tab_mem[tab_wa] <= tab_wd;
		end
		if (age_we) begin
			age_mem[tail_q] <= learn_slot;
		end
		rd_s1 <= tab_mem[addr_q];
		age_rd_q <= age_mem[head_q];
	end

	// Current item and read pipeline tags.
	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= item;
		end
		idx_s1 <= addr_q;
	end

	// Sequencer and table bookkeeping registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q <= '0;
			vld_s1 <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
			tick_q <= '0;
		end else begin
			state_q <= state_d;
			vld_s1 <= issue;
			if (state_q == ST_CLEAR || issue) begin
				addr_q <= (addr_q == LAST_IDX) ? '0 : addr_q + 1'b1;
			end
			if (head_inc) begin
				head_q <= ptr_inc(head_q);
			end
			if (tail_inc) begin
				tail_q <= ptr_inc(tail_q);
			end
			if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (tick_clr) begin
				tick_q <= '0;
			end else if (tick_inc) begin
				tick_q <= tick_nx;
			end
		end
	end

	// Scan results: source hit, destination hit and lowest free slot.
	always_ff @(posedge clk) begin
		if (start) begin
			src_hit_q <= 1'b0;
			dst_hit_q <= 1'b0;
			free_hit_q <= 1'b0;
		end else if (vld_s1) begin
			if (rd_valid && (rd_mac == cur_q.src_mac)) begin
				src_hit_q <= 1'b1;
				src_port_q <= rd_port;
			end
			if (rd_valid && (rd_mac == cur_q.dst_mac)) begin
				dst_hit_q <= 1'b1;
				dst_port_q <= rd_port;
				dst_idx_q <= idx_s1;
			end
			if (!rd_valid && !free_hit_q) begin
				free_hit_q <= 1'b1;
				free_idx_q <= idx_s1;
			end
		end
	end

endmodule
`default_nettype wire

/* test/two_port_learning_bridge_check.sv */
// Checker for the learning bridge: it predicts the table and compares each popped word.
`timescale 1ns / 1ps
`default_nettype none
module two_port_learning_bridge_check
	import tlb_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire logic                   full,
	input  wire logic                   opcode,
	input  wire logic [MAC_W-1:0]       src_mac,
	input  wire logic [MAC_W-1:0]       dst_mac,
	input  wire logic                   ingress_port,
	input  wire logic                   empty,
	input  wire logic                   pop,
	input  wire logic                   forward,
	input  wire logic                   egress_port,
	input  wire logic                   learned,
	input  wire logic                   evicted,
	input  wire logic [COUNT_OUT_W-1:0] entry_count,
	input  wire logic                   cfg_valid,
	input  wire logic                   cfg_ready,
	input  wire logic [PERIOD_W-1:0]    cfg_data,
	output int                          fail_count,
	output int                          pending
);

	// Predicted copy of the MAC table and its age queue.
	logic [MAC_W-1:0]    mac_tab [TABLE_DEPTH];
	logic                port_tab [TABLE_DEPTH];
	logic                valid_tab [TABLE_DEPTH];
	int                  age_slot [TABLE_DEPTH];
	int                  age_head;
	int                  age_tail;
	int                  live_entries;
	logic [PERIOD_W-1:0] seconds;
	logic [PERIOD_W-1:0] aging_period;
	result_t             due_words[$];

	function automatic int find_slot(logic [MAC_W-1:0] mac);
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (valid_tab[i] && mac_tab[i] == mac)
				return i;
		return -1;
	endfunction

	function automatic bit drop_oldest();
		if (live_entries == 0)
			return 0;
		valid_tab[age_slot[age_head]] = 1'b0;
		age_head = (age_head + 1) % TABLE_DEPTH;
		live_entries--;
		return 1;
	endfunction

	// Works out the result word of one accepted input word and moves the table on.
	function automatic result_t bridge_predict(item_t w);
		result_t             r;
		int                  s;
		int                  d;
		int                  free_slot;
		logic [PERIOD_W-1:0] period;
		r = '0;
		if (w.kind == KIND_TICK) begin
			period = (aging_period == '0) ? PERIOD_W'(1) : aging_period;
			seconds = seconds + 1'b1;
			if (seconds >= period) begin
				seconds = '0;
				r.evicted = drop_oldest();
			end
		end else begin
			s = find_slot(w.src_mac);
			if (s < 0) begin
				if (live_entries >= TABLE_DEPTH)
					r.evicted = drop_oldest();
				free_slot = -1;
				for (int i = TABLE_DEPTH - 1; i >= 0; i--)
					if (!valid_tab[i])
						free_slot = i;
				if (free_slot >= 0) begin
					mac_tab[free_slot] = w.src_mac;
					port_tab[free_slot] = w.ingress_port;
					valid_tab[free_slot] = 1'b1;
					age_slot[age_tail] = free_slot;
					age_tail = (age_tail + 1) % TABLE_DEPTH;
					live_entries++;
					r.learned = 1'b1;
					s = free_slot;
				end
			end
			d = find_slot(w.dst_mac);
			r.egress_port = ~w.ingress_port;
			r.forward = (s >= 0) && (port_tab[s] == w.ingress_port) &&
				(d < 0 || port_tab[d] != w.ingress_port);
		end
		r.entry_count = live_entries[COUNT_OUT_W-1:0];
		return r;
	endfunction

	// Watch the three channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		item_t   w;
		result_t got;
		result_t want;
		if (!arst_n) begin
			foreach (valid_tab[i])
				valid_tab[i] = 1'b0;
			age_head = 0;
			age_tail = 0;
			live_entries = 0;
			seconds = '0;
			aging_period = AGING_RESET;
			due_words.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				aging_period = cfg_data;
			if (pop && !empty) begin
				got = '{forward, egress_port, learned, evicted, entry_count};
				if (due_words.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word %h", got);
				end else begin
					want = due_words.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: fwd %b/%b egress %b/%b learned %b/%b evicted %b/%b count %0d/%0d (expected/actual)",
								want.forward, got.forward, want.egress_port, got.egress_port,
								want.learned, got.learned, want.evicted, got.evicted,
								want.entry_count, got.entry_count);
					end
				end
			end
			if (push && !full) begin
				w = '{kind_t'(opcode), src_mac, dst_mac, ingress_port};
				due_words.push_back(bridge_predict(w));
			end
		end
		pending = due_words.size();
	end

endmodule
`default_nettype wire

/* test/two_port_learning_bridge_test.sv */
// Testbench top for the learning bridge: stimulus, idling, pressure and the verdict.
`timescale 1ns / 1ps
`default_nettype none
module two_port_learning_bridge_test;
	import tlb_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_WORDS = 272;
	localparam int POOL_SIZE = 96;
	localparam int HOLD_LEN = 3000;

	logic                   clk;
	logic                   arst_n;
	logic                   push;
	logic                   full;
	logic                   opcode;
	logic [MAC_W-1:0]       src_mac;
	logic [MAC_W-1:0]       dst_mac;
	logic                   ingress_port;
	logic                   empty;
	logic                   pop;
	logic                   forward;
	logic                   egress_port;
	logic                   learned;
	logic                   evicted;
	logic [COUNT_OUT_W-1:0] entry_count;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [PERIOD_W-1:0]    cfg_data;
	int                     fail_count;
	int                     pending;
	int                     cycles;
	int                     tx_idle_pct;
	int                     rx_stall_pct;
	int                     hold_reqs;
	int                     hold_cycles;
	logic [MAC_W-1:0]       mac_pool [POOL_SIZE];

	two_port_learning_bridge #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .opcode(opcode),
		.src_mac(src_mac), .dst_mac(dst_mac), .ingress_port(ingress_port),
		.empty(empty), .pop(pop), .forward(forward), .egress_port(egress_port),
		.learned(learned), .evicted(evicted), .entry_count(entry_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	two_port_learning_bridge_check #(.TABLE_DEPTH(TABLE_DEPTH)) checker_i (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .opcode(opcode),
		.src_mac(src_mac), .dst_mac(dst_mac), .ingress_port(ingress_port),
		.empty(empty), .pop(pop), .forward(forward), .egress_port(egress_port),
		.learned(learned), .evicted(evicted), .entry_count(entry_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	// Clock of 10 ns period.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		int hold_seen;
		hold_seen = 0;
		hold_cycles = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_cycles = HOLD_LEN;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	function automatic logic [MAC_W-1:0] random_mac();
		return MAC_W'({$urandom(), $urandom()});
	endfunction

	// Offers one word and waits until the bridge takes it.
	task automatic send_word(item_t w);
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		opcode <= w.kind;
		src_mac <= w.src_mac;
		dst_mac <= w.dst_mac;
		ingress_port <= w.ingress_port;
		do
			@(posedge clk);
		while (full);
	endtask

	task automatic send_frame(logic [MAC_W-1:0] s, logic [MAC_W-1:0] d, logic p);
		send_word('{KIND_FRAME, s, d, p});
	endtask

	task automatic send_tick();
		send_word('{KIND_TICK, random_mac(), random_mac(), 1'($urandom())});
	endtask

	// Sender pause until every expected word has come back, then the back end settles.
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (2 * TABLE_DEPTH) @(posedge clk);
	endtask

	task automatic write_period(logic [PERIOD_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly frames between addresses of a shared pool, so that the table
	// hits, fills and evicts; some ticks and some wholly random addresses.
	task automatic send_random();
		logic [MAC_W-1:0] s;
		logic [MAC_W-1:0] d;
		int               pick;
		pick = $urandom_range(99);
		if (pick < 18) begin
			send_tick();
		end else begin
			s = ($urandom_range(99) < 88) ? mac_pool[$urandom_range(POOL_SIZE - 1)] :
				random_mac();
			if (pick < 23)
				d = s;
			else
				d = ($urandom_range(99) < 75) ? mac_pool[$urandom_range(POOL_SIZE - 1)] :
					random_mac();
			send_frame(s, d, 1'($urandom()));
		end
	endtask

	initial begin
		logic [PERIOD_W-1:0] periods [6];
		periods = '{16'd15, 16'd1, 16'd65535, 16'd0, 16'd3, 16'd2};
		arst_n = 1'b0;
		push = 1'b0;
		opcode = 1'b0;
		src_mac = '0;
		dst_mac = '0;
		ingress_port = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		cycles = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_reqs = 0;
		foreach (mac_pool[i])
			mac_pool[i] = random_mac();
		mac_pool[0] = '0;
		mac_pool[1] = '1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words at the reset aging period.
		send_frame('0, '1, 1'b0);
		send_frame('1, '0, 1'b1);
		send_frame('0, '1, 1'b0);
		send_frame('0, '1, 1'b1);
		send_frame('1, '1, 1'b1);
		send_frame(48'h0123_4567_89ab, '0, 1'b1);
		send_frame(48'h0123_4567_89ab, '1, 1'b1);
		send_frame(48'hfedc_ba98_7654, 48'h0123_4567_89ab, 1'b0);
		send_frame(48'h5555_5555_5555, 48'haaaa_aaaa_aaaa, 1'b0);
		send_word('{KIND_TICK, '1, '1, 1'b1});
		send_word('{KIND_TICK, '0, '0, 1'b0});
		repeat (14)
			send_tick();
		send_frame('0, 48'h0123_4567_89ab, 1'b0);
		drain();

		// Phases over aging settings and idling patterns.
		for (int ph = 0; ph < 6; ph++) begin
			write_period(periods[ph]);
			case (ph % 4)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 59;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 59;
				end
				default: begin
					tx_idle_pct = 13;
					rx_stall_pct = 13;
				end
			endcase
			if (ph == 2)
				hold_reqs++;
			// Short periods: a run of ticks first ages entries out of the table.
			if (periods[ph] <= 3)
				repeat (3 * TABLE_DEPTH / 2)
					send_tick();
			repeat (PHASE_WORDS - ((periods[ph] <= 3) ? 3 * TABLE_DEPTH / 2 : 0))
				send_random();
			drain();
		end

		tx_idle_pct = 0;
		rx_stall_pct = 0;
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire

/* two_port_learning_bridge.f */
sv/tlb_pkg.sv
sv/tlb_front.sv
sv/tlb_res_q.sv
sv/tlb_back.sv
sv/two_port_learning_bridge.sv
test/two_port_learning_bridge_check.sv
test/two_port_learning_bridge_test.sv
